[hdl/suart_pkg.sv]
// Shared types and constants for the sampled UART transceiver.
package suart_pkg;

  // Decoded operation kinds handed from the front end to the engine.
  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_EDGE = 2'd1,
    OP_PUSH = 2'd2,
    OP_NOP  = 2'd3
  } op_kind_t;

  // Raw command codes on the input port.
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_EDGE = 2'd1;
  localparam logic [1:0] CMD_PUSH = 2'd2;
  localparam logic [1:0] CMD_NOP  = 2'd3;

  // Bit slot limits of one frame.
  localparam int         SLOT_W     = 4;
  localparam logic [3:0] DATA_BITS  = 4'd8;
  localparam logic [3:0] LAST_SLOT  = 4'd10;
  localparam int         PHASE_W    = 8;

  // Decoupling queues: two entries, pointer and count widths.
  localparam int Q_DEPTH = 2;
  localparam int QP_W    = 1;
  localparam int QC_W    = 2;

  // One classified operation.
  typedef struct packed {
    op_kind_t    kind;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic        maj;
    logic        rx_level;
  } op_t;

  // One result transaction.
  typedef struct packed {
    logic        tx_line;
    logic        tx_active;
    logic        rx_active;
    logic        rx_valid;
    logic [7:0]  rx_byte;
    logic        rx_dropped;
    logic        push_accepted;
  } result_t;

  // Mode flags of the engine, exported for checking.
  typedef struct packed {
    logic sending;
    logic start_pending;
    logic receiving;
  } status_t;

endpackage

[hdl/suart_queue.sv]
// Two-entry register queue used between the front end, engine and result port.
module suart_queue import suart_pkg::*; #(
  parameter int W = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  logic [W-1:0]    store_r [Q_DEPTH];
  logic [QP_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QP_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  // Status and handshake qualification.
  assign full    = (count_r == QC_W'(Q_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = store_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[hdl/suart_front.sv]
// Front end: classifies raw input transactions into engine operations.
module suart_front import suart_pkg::*; (
  input  logic [1:0] in_command,
  input  logic [7:0] in_tx_byte,
  input  logic       in_tx_last,
  input  logic [2:0] in_rx_samples,
  input  logic       in_rx_level,
  output op_t        op
);

  // Command decode and three-sample majority vote.
  always_comb begin
    unique case (in_command)
      CMD_TICK: op.kind = OP_TICK;
      CMD_EDGE: op.kind = OP_EDGE;
      CMD_PUSH: op.kind = OP_PUSH;
      CMD_NOP:  op.kind = OP_NOP;
      default:  op.kind = OP_NOP;
    endcase
    op.tx_byte  = in_tx_byte;
    op.tx_last  = in_tx_last;
    op.maj      = (in_rx_samples[0] & in_rx_samples[1]) |
                  (in_rx_samples[0] & in_rx_samples[2]) |
                  (in_rx_samples[1] & in_rx_samples[2]);
    op.rx_level = in_rx_level;
  end

endmodule

[hdl/suart_back.sv]
// Engine: transmit buffer, shared bit counter and receive sampling.
module suart_back import suart_pkg::*; #(
  parameter int TX_DEPTH = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    op_valid,
  input  op_t     op,
  output logic    op_take,
  input  logic    res_full,
  output logic    res_push,
  output result_t res,
  output status_t status
);

  localparam int FW = $clog2(TX_DEPTH + 1);
  localparam int IW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

  logic [7:0]         tx_store_r [TX_DEPTH];
  logic [7:0]         rd_data_r;
  logic               wr_en;
  logic [IW-1:0]      wr_idx;

  logic [FW-1:0]      fill_r, fill_nxt;
  logic [FW-1:0]      left_r, left_nxt;
  logic [IW-1:0]      rd_idx_r, rd_idx_nxt;
  logic [IW-1:0]      load_idx_r, load_idx_nxt;
  logic [7:0]         tx_shift_r, tx_shift_nxt;
  logic               tx_level_r, tx_level_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [PHASE_W-1:0] phase_inc;
  status_t            mode_r, mode_nxt;
  logic [7:0]         rx_shift_r, rx_shift_nxt;
  logic [7:0]         tx_data;
  logic               busy;
  logic               fire;

  assign fire     = op_valid & ~res_full;
  assign op_take  = fire;
  assign res_push = fire;
  assign status   = mode_r;
  assign busy     = mode_r.sending | mode_r.start_pending | mode_r.receiving;
  assign phase_inc = phase_r + 1'b1;
  assign wr_idx   = fill_r[IW-1:0];
  // The first data slot takes the byte fetched from the buffer after the start slot.
  assign tx_data  = (slot_r == SLOT_W'(1)) ? rd_data_r : tx_shift_r;

  // Next-state logic for one operation.
  always_comb begin
    fill_nxt      = fill_r;
    left_nxt      = left_r;
    rd_idx_nxt    = rd_idx_r;
    load_idx_nxt  = load_idx_r;
    tx_shift_nxt  = tx_shift_r;
    tx_level_nxt  = tx_level_r;
    slot_nxt      = slot_r;
    phase_nxt     = phase_r;
    mode_nxt      = mode_r;
    rx_shift_nxt  = rx_shift_r;
    wr_en         = 1'b0;
    res           = '0;

    if (fire) begin
      unique case (op.kind)
        OP_TICK: begin
          if (busy) begin
            phase_nxt = phase_inc;
            if (phase_inc[0]) begin
              if (phase_inc == PHASE_W'(1) && mode_r.start_pending) begin
                // Start bit check by majority.
                mode_nxt.start_pending = 1'b0;
                if (!op.maj) begin
                  mode_nxt.receiving = 1'b1;
                  slot_nxt           = '0;
                end else begin
                  res.rx_dropped = 1'b1;
                end
              end else if (mode_r.sending) begin
                // Transmit slot.
                if (left_r == '0) begin
                  mode_nxt.sending = 1'b0;
                end else begin
                  if (slot_r == '0) begin
                    tx_level_nxt = 1'b0;
                    load_idx_nxt = rd_idx_r;
                    rd_idx_nxt   = (rd_idx_r == IW'(TX_DEPTH - 1)) ? '0 : rd_idx_r + 1'b1;
                  end else if (slot_r <= DATA_BITS) begin
                    tx_level_nxt = tx_data[0];
                    tx_shift_nxt = {1'b0, tx_data[7:1]};
                  end else begin
                    tx_level_nxt = 1'b1;
                  end
                  if (slot_r < LAST_SLOT) begin
                    slot_nxt = slot_r + 1'b1;
                  end else begin
                    slot_nxt = '0;
                    left_nxt = left_r - 1'b1;
                  end
                end
              end else if (mode_r.receiving) begin
                // Receive slot: data bits, then the stop check.
                if (slot_r < DATA_BITS) begin
                  rx_shift_nxt = {op.maj, rx_shift_r[7:1]};
                  slot_nxt     = slot_r + 1'b1;
                end else begin
                  if (op.maj && op.rx_level) begin
                    res.rx_valid = 1'b1;
                    res.rx_byte  = rx_shift_r;
                  end else begin
                    res.rx_dropped = 1'b1;
                  end
                  slot_nxt           = '0;
                  mode_nxt.receiving = 1'b0;
                end
              end
            end
          end
        end
        OP_EDGE: begin
          if (!mode_r.sending && !mode_r.receiving) begin
            phase_nxt              = '0;
            mode_nxt.start_pending = 1'b1;
          end
        end
        OP_PUSH: begin
          if (!busy) begin
            if (fill_r < FW'(TX_DEPTH)) begin
              wr_en             = 1'b1;
              fill_nxt          = fill_r + 1'b1;
              res.push_accepted = 1'b1;
            end
            if (op.tx_last) begin
              left_nxt         = fill_nxt;
              fill_nxt         = '0;
              rd_idx_nxt       = '0;
              slot_nxt         = '0;
              phase_nxt        = '0;
              mode_nxt.sending = 1'b1;
            end
          end
        end
        OP_NOP: begin
        end
        default: begin
        end
      endcase
    end

    res.tx_line   = tx_level_nxt;
    res.tx_active = mode_nxt.sending;
    res.rx_active = mode_nxt.start_pending | mode_nxt.receiving;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      left_r     <= '0;
      rd_idx_r   <= '0;
      load_idx_r <= '0;
      tx_shift_r <= '0;
      tx_level_r <= 1'b1;
      slot_r     <= '0;
      phase_r    <= '0;
      mode_r     <= '0;
      rx_shift_r <= '0;
    end else begin
      fill_r     <= fill_nxt;
      left_r     <= left_nxt;
      rd_idx_r   <= rd_idx_nxt;
      load_idx_r <= load_idx_nxt;
      tx_shift_r <= tx_shift_nxt;
      tx_level_r <= tx_level_nxt;
      slot_r     <= slot_nxt;
      phase_r    <= phase_nxt;
      mode_r     <= mode_nxt;
      rx_shift_r <= rx_shift_nxt;
    end
  end

  // Transmit buffer: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tx_store_r[wr_idx] <= op.tx_byte;
    end
    rd_data_r <= tx_store_r[load_idx_r];
  end

endmodule

[hdl/sampled_uart_transceiver.sv]
// Top level of the half-duplex sampled UART transceiver.
// Half-duplex UART (8N1 receive, 8N2 transmit) stepped by transactions: half-bit
// ticks, receive falling edges and transmit byte pushes, each answered by exactly one
// result transaction. The block takes one transaction per clock for as long as
// results are popped; the rate is set by the engine, which applies one operation per
// clock to its state. An accepted transaction is stored in the operation queue, and
// its result in the result queue, which drives the result ports. Two-entry queues
// sit before and after the engine, so a short stall on one side does not stop the
// other. Once the result side stops popping, full rises as soon as both queues have
// filled. The transmit buffer holds TX_DEPTH bytes and needs no clearing after reset.
module sampled_uart_transceiver import suart_pkg::*; #(
  parameter int TX_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [1:0] in_command,
  input  logic [7:0] in_tx_byte,
  input  logic       in_tx_last,
  input  logic [2:0] in_rx_samples,
  input  logic       in_rx_level,
  output logic       empty,
  input  logic       pop,
  output logic       out_tx_line,
  output logic       out_tx_active,
  output logic       out_rx_active,
  output logic       out_rx_valid,
  output logic [7:0] out_rx_byte,
  output logic       out_rx_dropped,
  output logic       out_push_accepted
);

  op_t     front_op;
  op_t     head_op;
  logic    op_empty;
  logic    op_take;
  result_t eng_res;
  result_t out_res;
  logic    res_push;
  logic    res_full;
  status_t status;

  // Classify incoming transactions.
  suart_front u_front (
    .in_command    (in_command),
    .in_tx_byte    (in_tx_byte),
    .in_tx_last    (in_tx_last),
    .in_rx_samples (in_rx_samples),
    .in_rx_level   (in_rx_level),
    .op            (front_op)
  );

  // Queue of classified operations.
  suart_queue #(.W($bits(op_t))) u_op_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (front_op),
    .full  (full),
    .pop   (op_take),
    .rdata (head_op),
    .empty (op_empty)
  );

  // Engine.
  suart_back #(.TX_DEPTH(TX_DEPTH)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (~op_empty),
    .op       (head_op),
    .op_take  (op_take),
    .res_full (res_full),
    .res_push (res_push),
    .res      (eng_res),
    .status   (status)
  );

  // Queue of finished results.
  suart_queue #(.W($bits(result_t))) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (eng_res),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_res),
    .empty (empty)
  );

  assign out_tx_line       = out_res.tx_line;
  assign out_tx_active     = out_res.tx_active;
  assign out_rx_active     = out_res.rx_active;
  assign out_rx_valid      = out_res.rx_valid;
  assign out_rx_byte       = out_res.rx_byte;
  assign out_rx_dropped    = out_res.rx_dropped;
  assign out_push_accepted = out_res.push_accepted;

`ifndef ASSERT_OFF
  // Sending, start check and reception exclude each other.
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({status.sending, status.start_pending, status.receiving}))
    else $error("UART engine has more than one mode active");

  // The engine only produces a result when the result queue has room.
  assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("Result produced while the result queue is full");

  // A finished reception is either kept or dropped, never both.
  assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !(eng_res.rx_valid && eng_res.rx_dropped))
    else $error("Reception both kept and dropped");
`endif

endmodule

[tb/sampled_uart_transceiver_tb.sv]
// Self-checking testbench for the sampled UART transceiver: directed table, then random traffic.
`timescale 1ns / 1ps

module sampled_uart_transceiver_tb;
  import suart_pkg::*;

  localparam int BUF_DEPTH    = 16;
  localparam int ITEM_GOAL    = 850;
  localparam int STALL_LIMIT  = 500;
  localparam int DRAIN_CYCLES = 20;
  localparam int SCRIPT_LEN   = 16;

  // One input transaction, field by field.
  typedef struct packed {
    logic [1:0] command;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic [2:0] rx_samples;
    logic       rx_level;
  } uart_item_t;

  // One row of the directed table; want is used only when typed is set.
  typedef struct packed {
    uart_item_t item;
    logic [7:0] reps;
    logic       typed;
    result_t    want;
  } row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [1:0] in_command = CMD_NOP;
  logic [7:0] in_tx_byte = 8'h00;
  logic       in_tx_last = 1'b0;
  logic [2:0] in_rx_samples = 3'b000;
  logic       in_rx_level = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic       out_tx_line;
  logic       out_tx_active;
  logic       out_rx_active;
  logic       out_rx_valid;
  logic [7:0] out_rx_byte;
  logic       out_rx_dropped;
  logic       out_push_accepted;

  // Predicted UART state.
  logic [7:0] tx_buf [BUF_DEPTH];
  logic [4:0] tx_fill = '0;
  logic [3:0] tx_rd_ptr = '0;
  logic [4:0] tx_bytes_left = '0;
  logic [7:0] tx_sr = '0;
  logic       line_level = 1'b1;
  logic [3:0] slot_cnt = '0;
  logic [7:0] half_tick = '0;
  status_t    mode = '0;
  logic [7:0] rx_sr = '0;

  result_t    predicted_results [$];
  int         mismatches = 0;
  int         items_sent = 0;
  int         stall_cycles = 0;
  logic       steady = 1'b0;
  row_t       script [SCRIPT_LEN];

  sampled_uart_transceiver #(.TX_DEPTH(BUF_DEPTH)) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_command        (in_command),
    .in_tx_byte        (in_tx_byte),
    .in_tx_last        (in_tx_last),
    .in_rx_samples     (in_rx_samples),
    .in_rx_level       (in_rx_level),
    .empty             (empty),
    .pop               (pop),
    .out_tx_line       (out_tx_line),
    .out_tx_active     (out_tx_active),
    .out_rx_active     (out_rx_active),
    .out_rx_valid      (out_rx_valid),
    .out_rx_byte       (out_rx_byte),
    .out_rx_dropped    (out_rx_dropped),
    .out_push_accepted (out_push_accepted)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic vote3(logic [2:0] s);
    return (s[0] & s[1]) | (s[0] & s[2]) | (s[1] & s[2]);
  endfunction

  // Three random line samples whose majority is the wanted level.
  function automatic logic [2:0] pick_samples(logic want);
    logic [2:0] s;
    do s = 3'($urandom_range(0, 7)); while (vote3(s) != want);
    return s;
  endfunction

  function automatic uart_item_t any_item(logic [1:0] cmd);
    uart_item_t it;
    it.command    = cmd;
    it.tx_byte    = 8'($urandom_range(0, 255));
    it.tx_last    = 1'($urandom_range(0, 1));
    it.rx_samples = 3'($urandom_range(0, 7));
    it.rx_level   = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic result_t outcome(logic line, logic txa, logic rxa, logic valid,
                                      logic [7:0] data, logic dropped, logic accepted);
    result_t r;
    r.tx_line       = line;
    r.tx_active     = txa;
    r.rx_active     = rxa;
    r.rx_valid      = valid;
    r.rx_byte       = data;
    r.rx_dropped    = dropped;
    r.push_accepted = accepted;
    return r;
  endfunction

  function automatic row_t row(logic [1:0] cmd, logic [7:0] data, logic last,
                               logic [2:0] samples, logic level, int n, logic typed,
                               result_t want);
    row_t r;
    r.item  = '{command: cmd, tx_byte: data, tx_last: last, rx_samples: samples,
                rx_level: level};
    r.reps  = 8'(n);
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  // Applies one transaction to the predicted state and returns the UART status it yields.
  task automatic uart_advance(input uart_item_t it, output result_t r);
    logic m;
    r = '0;
    case (it.command)
      CMD_TICK: begin
        if (mode != '0) begin
          half_tick = half_tick + 8'd1;
          if (half_tick[0]) begin
            if (half_tick == 8'd1 && mode.start_pending) begin
              // Start bit check: a low majority opens reception, a high one is a glitch.
              mode.start_pending = 1'b0;
              if (!vote3(it.rx_samples)) begin
                mode.receiving = 1'b1;
                slot_cnt = '0;
              end else begin
                r.rx_dropped = 1'b1;
              end
            end else begin
              if (mode.sending) begin
                if (tx_bytes_left == '0) begin
                  mode.sending = 1'b0;
                end else begin
                  if (slot_cnt == '0) begin
                    line_level = 1'b0;
                    tx_sr = tx_buf[tx_rd_ptr];
                    tx_rd_ptr = tx_rd_ptr + 4'd1;
                  end else if (slot_cnt <= DATA_BITS) begin
                    line_level = tx_sr[0];
                    tx_sr = tx_sr >> 1;
                  end else begin
                    line_level = 1'b1;
                  end
                  if (slot_cnt < LAST_SLOT) begin
                    slot_cnt = slot_cnt + 4'd1;
                  end else begin
                    slot_cnt = '0;
                    tx_bytes_left = tx_bytes_left - 5'd1;
                  end
                end
              end
              if (mode.receiving) begin
                m = vote3(it.rx_samples);
                if (slot_cnt < DATA_BITS) begin
                  rx_sr = {m, rx_sr[7:1]};
                  slot_cnt = slot_cnt + 4'd1;
                end else begin
                  // Stop check needs both the majority and the extra read high.
                  if (m && it.rx_level) begin
                    r.rx_valid = 1'b1;
                    r.rx_byte  = rx_sr;
                  end else begin
                    r.rx_dropped = 1'b1;
                  end
                  slot_cnt = '0;
                  mode.receiving = 1'b0;
                end
              end
            end
          end
        end
      end
      CMD_EDGE: begin
        if (!mode.sending && !mode.receiving) begin
          half_tick = '0;
          mode.start_pending = 1'b1;
        end
      end
      CMD_PUSH: begin
        if (mode == '0) begin
          if (tx_fill < 5'(BUF_DEPTH)) begin
            tx_buf[tx_fill[3:0]] = it.tx_byte;
            tx_fill = tx_fill + 5'd1;
            r.push_accepted = 1'b1;
          end
          if (it.tx_last) begin
            tx_bytes_left = tx_fill;
            tx_fill = '0;
            tx_rd_ptr = '0;
            slot_cnt = '0;
            half_tick = '0;
            mode.sending = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.tx_line   = line_level;
    r.tx_active = mode.sending;
    r.rx_active = mode.start_pending | mode.receiving;
  endtask

  // Offers one transaction, holds it until accepted, then records its expected status.
  task automatic send_item(input uart_item_t it, input logic typed = 1'b0,
                           input result_t want = '0);
    result_t r;
    while (!steady && $urandom_range(0, 99) < 36) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push          <= 1'b1;
    in_command    <= it.command;
    in_tx_byte    <= it.tx_byte;
    in_tx_last    <= it.tx_last;
    in_rx_samples <= it.rx_samples;
    in_rx_level   <= it.rx_level;
    @(posedge clk);
    while (full) @(posedge clk);
    uart_advance(it, r);
    predicted_results.push_back(typed ? want : r);
    items_sent++;
    steady <= (items_sent >= 300) && (items_sent < 420);
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Result side: random pop stalls and comparison of every popped transaction.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && pop && !empty) begin
      if (predicted_results.size() == 0) begin
        $error("result transaction arrived with nothing predicted");
        mismatches++;
      end else begin
        want = predicted_results.pop_front();
        check_field("tx_line", 8'(want.tx_line), 8'(out_tx_line));
        check_field("tx_active", 8'(want.tx_active), 8'(out_tx_active));
        check_field("rx_active", 8'(want.rx_active), 8'(out_rx_active));
        check_field("rx_valid", 8'(want.rx_valid), 8'(out_rx_valid));
        check_field("rx_byte", want.rx_byte, out_rx_byte);
        check_field("rx_dropped", 8'(want.rx_dropped), 8'(out_rx_dropped));
        check_field("push_accepted", 8'(want.push_accepted), 8'(out_push_accepted));
      end
    end
    pop <= rst_n && (steady || ($urandom_range(0, 99) >= 36));
  end

  // Watchdog: ends the run when no transaction moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    uart_item_t it;
    int         pick;
    int         n;
    int         k;
    int         content;

    script = '{
      // Idle tick and unused command leave the line idle.
      row(CMD_TICK, 8'h00, 0, 3'b000, 0, 1, 1, outcome(1, 0, 0, 0, 8'h00, 0, 0)),
      row(CMD_NOP,  8'hFF, 1, 3'b111, 1, 1, 1, outcome(1, 0, 0, 0, 8'h00, 0, 0)),
      // Falling edge arms the start check; a push is refused meanwhile.
      row(CMD_EDGE, 8'h00, 0, 3'b000, 0, 1, 1, outcome(1, 0, 1, 0, 8'h00, 0, 0)),
      row(CMD_PUSH, 8'h5A, 1, 3'b000, 0, 1, 1, outcome(1, 0, 1, 0, 8'h00, 0, 0)),
      // A further edge restarts the check, then a high majority is a start glitch.
      row(CMD_EDGE, 8'h00, 0, 3'b000, 0, 1, 0, '0),
      row(CMD_TICK, 8'h00, 0, 3'b011, 0, 1, 1, outcome(1, 0, 0, 0, 8'h00, 1, 0)),
      // Good start, then a push and an edge during reception are both ignored.
      row(CMD_EDGE, 8'h00, 0, 3'b000, 0, 1, 0, '0),
      row(CMD_TICK, 8'h00, 0, 3'b100, 0, 1, 0, '0),
      row(CMD_PUSH, 8'hC3, 1, 3'b000, 0, 1, 0, '0),
      row(CMD_EDGE, 8'h00, 0, 3'b000, 0, 1, 0, '0),
      // All data bits high, then a good stop delivers 0xFF.
      row(CMD_TICK, 8'h00, 0, 3'b111, 0, 17, 0, '0),
      row(CMD_TICK, 8'h00, 0, 3'b111, 1, 1, 1, outcome(1, 0, 0, 1, 8'hFF, 0, 0)),
      // Two-byte string; a third push while sending is refused, an edge ignored.
      row(CMD_PUSH, 8'h00, 0, 3'b000, 0, 1, 1, outcome(1, 0, 0, 0, 8'h00, 0, 1)),
      row(CMD_PUSH, 8'hFF, 1, 3'b000, 0, 1, 1, outcome(1, 1, 0, 0, 8'h00, 0, 1)),
      row(CMD_PUSH, 8'h81, 1, 3'b000, 0, 1, 1, outcome(1, 1, 0, 0, 8'h00, 0, 0)),
      row(CMD_EDGE, 8'h00, 0, 3'b000, 0, 1, 0, '0)
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table.
    for (int r = 0; r < SCRIPT_LEN; r++) begin
      for (int j = 0; j < int'(script[r].reps); j++) begin
        send_item(script[r].item, script[r].typed, script[r].want);
      end
    end

    // Random traffic: mostly well-formed strings and frames with random content.
    while (items_sent < ITEM_GOAL) begin
      // Let any transfer in progress finish with random line samples.
      while (mode != '0) send_item(any_item(CMD_TICK));
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // Transmit string; now and then long enough to fill the buffer.
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 18) : $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
          it = any_item(CMD_PUSH);
          it.tx_last = (i == n - 1);
          send_item(it);
        end
        while (mode.sending) begin
          k = $urandom_range(0, 19);
          if (k == 0) it = any_item(CMD_EDGE);
          else if (k == 1) it = any_item(CMD_PUSH);
          else if (k == 2) it = any_item(CMD_NOP);
          else it = any_item(CMD_TICK);
          send_item(it);
        end
      end else if (pick < 80) begin
        // Receive frame: edge, start check, data bits, stop check.
        send_item(any_item(CMD_EDGE));
        if ($urandom_range(0, 4) == 0) send_item(any_item(CMD_EDGE));
        it = any_item(CMD_TICK);
        if ($urandom_range(0, 4) != 0) it.rx_samples = pick_samples(1'b0);
        send_item(it);
        content = $urandom_range(0, 3);
        while (mode.receiving) begin
          k = $urandom_range(0, 19);
          if (k == 0) it = any_item(CMD_EDGE);
          else if (k == 1) it = any_item(CMD_PUSH);
          else if (k == 2) it = any_item(CMD_NOP);
          else it = any_item(CMD_TICK);
          if (it.command == CMD_TICK && !half_tick[0]) begin
            // Next tick is odd, so it samples a bit.
            if (slot_cnt < DATA_BITS) begin
              if (content == 0) it.rx_samples = pick_samples(1'b1);
              else if (content == 1) it.rx_samples = pick_samples(1'b0);
            end else if ($urandom_range(0, 3) != 0) begin
              it.rx_samples = pick_samples(1'b1);
              it.rx_level   = 1'b1;
            end
          end
          send_item(it);
        end
      end else begin
        // Short burst of arbitrary commands.
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) send_item(any_item(2'($urandom_range(0, 3))));
      end
    end
    push <= 1'b0;

    while (predicted_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && predicted_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/suart_pkg.sv
hdl/suart_queue.sv
hdl/suart_front.sv
hdl/suart_back.sv
hdl/sampled_uart_transceiver.sv
tb/sampled_uart_transceiver_tb.sv
